// ===== sv/urhr_pkg.sv =====
// shared types and constants for the undo/redo history ring
// no dependencies; used by urhr_ram users and the top level
`default_nettype none

package urhr_pkg;

    // storage geometry
    localparam int HISTORY_DEPTH  = 64;
    localparam int SNAPSHOT_WIDTH = 64;
    localparam int TAG_W          = 32;
    localparam int OP_W           = 2;
    localparam int DEPTH_W        = 7;
    localparam int ADDR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W          = $clog2(HISTORY_DEPTH + 1);

    // stream word widths
    localparam int S_FIELDS_W = OP_W + SNAPSHOT_WIDTH + TAG_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 1 + SNAPSHOT_WIDTH + 1 + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // apb
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DEPTH_IN_USE = 1'b0;
    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd64;

    // operation codes
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd0;
    localparam logic [OP_W-1:0] OP_UNDO   = 2'd1;
    localparam logic [OP_W-1:0] OP_REDO   = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

`default_nettype wire

// ===== sv/urhr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module urhr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/undo_redo_history_ring.sv =====
// undo/redo history ring: bounded snapshot history with a cursor
// depends on urhr_pkg and urhr_ram
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+---------------------------------------------
//  s_*       | in  | s_tvalid/s_tready  | operation, snapshot_in, commit_tag
//  m_*       | out | m_tvalid/m_tready  | accepted, snapshot_out, can_undo, can_redo
//  apb       | in  | psel/penable       | depth_in_use at byte address 0
//
// each word has an accept step and an execute step: the accept step issues the store read
// at the slot the cursor points to for commit, below it for undo, above it for redo; the
// execute step compares, writes back and loads the result
// the execute cycle waits while the result register is full and not being taken
// reset clears cursor, count, oldest slot and last tag; the store itself is not cleared
// writing depth_in_use empties the history at once
`default_nettype none

module undo_redo_history_ring (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // fields from bit 0: operation[2], snapshot_in[64], commit_tag[32], zero fill
    input  wire logic [urhr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // fields from bit 0: accepted[1], snapshot_out[64], can_undo[1], can_redo[1], zero fill
    output logic      [urhr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [urhr_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [urhr_pkg::PDATA_W-1:0]     pwdata,
    output logic      [urhr_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    localparam int AW = urhr_pkg::ADDR_W;
    localparam int CW = urhr_pkg::CNT_W;
    localparam int SW = urhr_pkg::SNAPSHOT_WIDTH;
    localparam int TW = urhr_pkg::TAG_W;

    // slot = (oldest + logical) mod depth, with both terms below depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] lidx,
                                              input logic [CW-1:0] dep);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, lidx};
        if (sum >= {1'b0, dep})
        begin
            sum = sum - {1'b0, dep};
        end
        return sum[AW-1:0];
    endfunction

    // ---------------------------------------------------------------- state
    urhr_pkg::state_t state_reg, state_next;

    logic [urhr_pkg::DEPTH_W-1:0] depth_reg;
    logic [AW-1:0]                oldest_reg, oldest_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [AW-1:0]                cur_reg, cur_next;     // valid while count is nonzero
    logic [TW-1:0]                prev_tag_reg, prev_tag_next;

    // accepted word held for the execute cycle
    logic [urhr_pkg::OP_W-1:0]    op_reg;
    logic [SW-1:0]                snap_reg;
    logic [TW-1:0]                tag_reg;

    logic                         m_tvalid_reg;
    logic [urhr_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ---------------------------------------------------------------- config
    logic cfg_wr;
    logic [CW-1:0] eff_depth;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == urhr_pkg::REG_DEPTH_IN_USE) && (paddr[1:0] == 2'b00);
    assign prdata = (paddr[2] == urhr_pkg::REG_DEPTH_IN_USE)
                  ? {{(urhr_pkg::PDATA_W - urhr_pkg::DEPTH_W){1'b0}}, depth_reg}
                  : '0;

    // zero acts as one, above the store size saturates
    always_comb
    begin
        if (depth_reg == '0)
        begin
            eff_depth = CW'(1);
        end
        else if (32'(depth_reg) > 32'(urhr_pkg::HISTORY_DEPTH))
        begin
            eff_depth = CW'(urhr_pkg::HISTORY_DEPTH);
        end
        else
        begin
            eff_depth = CW'(depth_reg);
        end
    end

    // ---------------------------------------------------------------- input unpack
    logic [urhr_pkg::OP_W-1:0] in_op;
    logic [SW-1:0]             in_snap;
    logic [TW-1:0]             in_tag;

    assign in_op   = s_tdata[urhr_pkg::OP_W-1:0];
    assign in_snap = s_tdata[urhr_pkg::OP_W +: SW];
    assign in_tag  = s_tdata[urhr_pkg::OP_W + SW +: TW];

    // ---------------------------------------------------------------- fsm
    logic s_fire, out_free, exec_go;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urhr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = urhr_pkg::ST_EXEC;
                end
            end
            urhr_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = urhr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = urhr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        exec_go  = 1'b0;
        case (state_reg)
            urhr_pkg::ST_IDLE: s_tready = 1'b1;
            urhr_pkg::ST_EXEC: exec_go  = out_free;
            default:           s_tready = 1'b0;
        endcase
    end

    assign s_fire = s_tvalid && s_tready;

    // ---------------------------------------------------------------- read address
    // commit reads the current entry, undo the one below, redo the one above
    logic [CW-1:0] rd_lidx;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] cur_ext;

    assign cur_ext = {{(CW - AW){1'b0}}, cur_reg};

    always_comb
    begin
        case (in_op)
            urhr_pkg::OP_UNDO: rd_lidx = cur_ext - CW'(1);
            urhr_pkg::OP_REDO: rd_lidx = cur_ext + CW'(1);
            default:           rd_lidx = cur_ext;
        endcase
        rd_addr = slot_of(oldest_reg, rd_lidx, eff_depth);
    end

    // ---------------------------------------------------------------- store
    logic          ram_we, wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] rd_data;

    urhr_ram #(
        .WIDTH (SW),
        .DEPTH (urhr_pkg::HISTORY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (snap_reg),
        .re    (s_fire),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign ram_we = exec_go && wr_en;

    // ---------------------------------------------------------------- execute
    logic          have, at_top, coalesce, ok;
    logic [CW-1:0] push_idx;
    logic [SW-1:0] restored;
    logic          can_undo, can_redo;

    always_comb
    begin
        have          = (count_reg != '0);
        at_top        = have && ((cur_ext + CW'(1)) == count_reg);
        coalesce      = (tag_reg != '0) && (tag_reg == prev_tag_reg) && at_top;
        push_idx      = have ? (cur_ext + CW'(1)) : '0;
        ok            = 1'b0;
        restored      = '0;
        wr_en         = 1'b0;
        wr_addr       = cur_reg;
        oldest_next   = oldest_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        prev_tag_next = prev_tag_reg;

        case (op_reg)
            urhr_pkg::OP_COMMIT:
            begin
                if (!(have && (rd_data == snap_reg)))
                begin
                    ok    = 1'b1;
                    wr_en = 1'b1;
                    if (coalesce)
                    begin
                        wr_addr = slot_of(oldest_reg, cur_ext, eff_depth);
                    end
                    else
                    begin
                        prev_tag_next = tag_reg;
                        if (push_idx >= eff_depth)
                        begin
                            // full: oldest slot is reused for the new top
                            wr_addr = oldest_reg;
                            if (({1'b0, oldest_reg} + CW'(1)) >= eff_depth)
                            begin
                                oldest_next = '0;
                            end
                            else
                            begin
                                oldest_next = oldest_reg + AW'(1);
                            end
                            cur_next   = AW'(eff_depth - CW'(1));
                            count_next = eff_depth;
                        end
                        else
                        begin
                            wr_addr    = slot_of(oldest_reg, push_idx, eff_depth);
                            cur_next   = push_idx[AW-1:0];
                            count_next = push_idx + CW'(1);
                        end
                    end
                end
            end
            urhr_pkg::OP_UNDO:
            begin
                if (have && (cur_reg != '0))
                begin
                    ok            = 1'b1;
                    restored      = rd_data;
                    cur_next      = cur_reg - AW'(1);
                    prev_tag_next = '0;
                end
            end
            urhr_pkg::OP_REDO:
            begin
                if (have && !at_top)
                begin
                    ok            = 1'b1;
                    restored      = rd_data;
                    cur_next      = cur_reg + AW'(1);
                    prev_tag_next = '0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        can_undo = (count_next != '0) && (cur_next != '0);
        can_redo = (count_next != '0) &&
                   (({{(CW - AW){1'b0}}, cur_next} + CW'(1)) < count_next);

        m_tdata_next = '0;
        m_tdata_next[urhr_pkg::M_FIELDS_W-1:0] = {can_redo, can_undo, restored, ok};
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= urhr_pkg::ST_IDLE;
            depth_reg    <= urhr_pkg::DEPTH_RESET;
            oldest_reg   <= '0;
            count_reg    <= '0;
            cur_reg      <= '0;
            prev_tag_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                depth_reg    <= pwdata[urhr_pkg::DEPTH_W-1:0];
                oldest_reg   <= '0;
                count_reg    <= '0;
                cur_reg      <= '0;
                prev_tag_reg <= '0;
            end
            else if (exec_go)
            begin
                oldest_reg   <= oldest_next;
                count_reg    <= count_next;
                cur_reg      <= cur_next;
                prev_tag_reg <= prev_tag_next;
            end
            if (exec_go)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg   <= in_op;
            snap_reg <= in_snap;
            tag_reg  <= in_tag;
        end
        if (exec_go)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // the history never holds more entries than the depth in use
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_depth)
        else $error("entry count above depth in use");

    // the cursor stays inside the stored entries
    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> ({{(CW - AW){1'b0}}, cur_reg} < count_reg))
        else $error("cursor beyond stored entries");

    // the oldest slot stays inside the ring
    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(CW - AW){1'b0}}, oldest_reg} < eff_depth)
        else $error("oldest slot outside ring");

    // a result appears only after an execute cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == urhr_pkg::ST_EXEC))
        else $error("result without execute cycle");

    // the store is written only while a word is being executed
    a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == urhr_pkg::ST_EXEC) && out_free)
        else $error("store write outside execute");
`endif

endmodule

`default_nettype wire
